// File: rtl/sbda_pkg.sv
package sbda_pkg;

    // input and conversion widths
    localparam int BITS   = 32;
    localparam int DIGITS = 10;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int CNT_W  = $clog2(BITS);
    localparam int NDIG_W = $clog2(DIGITS + 1);
    localparam int CHAR_W = 6;

    // ascii codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    // top level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // add three to a bcd digit of five or more, before the next shift
    function automatic logic [3:0] add3(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? 4'(d + 4'd3) : d;
        return r;
    endfunction

endpackage

// File: rtl/sbda_dabble.sv
module sbda_dabble (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sbda_pkg::BITS-1:0]   mag,
    output logic                        done,
    output logic [sbda_pkg::BCD_W-1:0]  bcd
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [sbda_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [sbda_pkg::BITS-1:0]     mag_reg, mag_next;
    logic [sbda_pkg::BCD_W-1:0]    bcd_reg, bcd_next;
    logic [sbda_pkg::BCD_W-1:0]    adj;

    // per-digit correction, digits are independent
    always_comb
    begin
        for (int i = 0; i < sbda_pkg::DIGITS; i++)
        begin
            adj[i*4 +: 4] = sbda_pkg::add3(bcd_reg[i*4 +: 4]);
        end
    end

    // one magnitude bit shifted into the bcd word per cycle while busy
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mag_next  = mag;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[sbda_pkg::BCD_W-2:0], mag_reg[sbda_pkg::BITS-1]};
            mag_next = {mag_reg[sbda_pkg::BITS-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sbda_pkg::CNT_W'(sbda_pkg::BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// File: rtl/signed_binary_to_decimal_ascii.sv
// Converts one signed 32-bit two's complement value per input transfer into its decimal
// ASCII text, most significant character first, one character per output transfer:
// a minus sign leads for negative values, there are no leading zeros, zero gives a
// single '0', and tlast marks the final digit. The most negative value gives all 11
// characters. A value is taken, converted by the bit-serial double-dabble shifter
// and its result loaded, its leading zero digits are dropped one at a time, then
// the minus sign and the digits are emitted. A new value is taken only once the
// previous one has been handed to the output register.
module signed_binary_to_decimal_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] character, [7:6] zero
    output logic        m_axis_tlast
);

    sbda_pkg::state_t                state_reg, state_next;
    logic                            neg_reg, neg_next;
    logic [sbda_pkg::BCD_W-1:0]      digits_reg, digits_next;
    logic [sbda_pkg::NDIG_W-1:0]     ndig_reg, ndig_next;
    logic                            out_valid_reg, out_valid_next;
    logic [sbda_pkg::CHAR_W-1:0]     out_char_reg, out_char_next;
    logic                            out_last_reg, out_last_next;

    logic                            start;
    logic [sbda_pkg::BITS-1:0]       mag;
    logic                            conv_done;
    logic [sbda_pkg::BCD_W-1:0]      conv_bcd;
    logic [3:0]                      top_digit;
    logic                            out_free;

    // magnitude of the incoming value, unsigned so the most negative value works
    assign mag = s_axis_tdata[31] ? (32'd0 - s_axis_tdata) : s_axis_tdata;

    sbda_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mag   (mag),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    assign top_digit = digits_reg[sbda_pkg::BCD_W-1 -: 4];
    assign out_free  = !out_valid_reg || m_axis_tready;

    // sequencer: accept, convert, drop leading zeros, emit sign and digits
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        digits_next    = digits_reg;
        ndig_next      = ndig_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        start          = 1'b0;
        s_axis_tready  = 1'b0;
        unique case (state_reg)
            sbda_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    start      = 1'b1;
                    neg_next   = s_axis_tdata[31];
                    state_next = sbda_pkg::ST_CONV;
                end
            end
            sbda_pkg::ST_CONV:
            begin
                if (conv_done)
                begin
                    digits_next = conv_bcd;
                    ndig_next   = sbda_pkg::NDIG_W'(sbda_pkg::DIGITS);
                    state_next  = sbda_pkg::ST_SKIP;
                end
            end
            sbda_pkg::ST_SKIP:
            begin
                if (top_digit == 4'd0 && ndig_reg > sbda_pkg::NDIG_W'(1))
                begin
                    digits_next = {digits_reg[sbda_pkg::BCD_W-5:0], 4'd0};
                    ndig_next   = ndig_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? sbda_pkg::ST_SIGN : sbda_pkg::ST_EMIT;
                end
            end
            sbda_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = sbda_pkg::ASCII_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = sbda_pkg::ST_EMIT;
                end
            end
            sbda_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = sbda_pkg::ASCII_ZERO + {2'b00, top_digit};
                    out_last_next  = (ndig_reg == sbda_pkg::NDIG_W'(1));
                    digits_next    = {digits_reg[sbda_pkg::BCD_W-5:0], 4'd0};
                    ndig_next      = ndig_reg - 1'b1;
                    if (ndig_reg == sbda_pkg::NDIG_W'(1))
                    begin
                        state_next = sbda_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sbda_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbda_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        digits_reg   <= digits_next;
        ndig_reg     <= ndig_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: rtl/sbda_checker.sv
module sbda_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled output transfer stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transfer withdrawn while stalled");

    // only a minus sign or a digit leaves the block
    a_out_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata == 8'd45) ||
                          (m_axis_tdata >= 8'd48 && m_axis_tdata <= 8'd57))
        else $error("output character out of range");

    // the final character of a number is always a digit
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata != 8'd45)
        else $error("minus sign marked as last");

    // an accepted value occupies the converter
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second value taken during conversion");

    // a minus sign is never followed by another minus sign
    a_sign_once: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata == 8'd45 |=>
        !(m_axis_tvalid && m_axis_tdata == 8'd45))
        else $error("repeated minus sign");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 200;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT = 500000;

    // one character of decimal text as it should leave the block
    typedef struct packed {
        logic [sbda_pkg::CHAR_W-1:0] character;
        logic                        last;
    } ascii_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [5:0] character, [7:6] zero
    logic        m_axis_tlast;

    // characters still owed by the block, oldest first
    ascii_char_t expected_chars[$];
    // typed text for each value offered, empty where the predictor decides
    string       offered_text[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;

    signed_binary_to_decimal_ascii dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // predictor: decimal digits of the magnitude, sign first, last flag on the final digit
    function automatic void expect_decimal(input logic [31:0] value);
        logic [31:0] mag;
        logic [3:0]  digit [10];
        int          count;
        mag = value[31] ? (~value + 32'd1) : value;
        count = 0;
        do
        begin
            digit[count] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            count++;
        end
        while (mag != 32'd0);
        if (value[31])
        begin
            expected_chars.push_back('{sbda_pkg::ASCII_MINUS, 1'b0});
        end
        for (int k = count - 1; k >= 0; k--)
        begin
            expected_chars.push_back('{sbda_pkg::CHAR_W'(sbda_pkg::ASCII_ZERO + digit[k]),
                                       k == 0});
        end
    endfunction

    // typed text straight from the table
    function automatic void expect_text(input string text);
        for (int k = 0; k < text.len(); k++)
        begin
            expected_chars.push_back('{sbda_pkg::CHAR_W'(text[k]), k == text.len() - 1});
        end
    endfunction

    task automatic take_value(input logic [31:0] value);
        string text;
        if (offered_text.size() == 0)
        begin
            report_mismatch("input transfer with no value offered");
        end
        else
        begin
            text = offered_text.pop_front();
            if (text == "")
            begin
                expect_decimal(value);
            end
            else
            begin
                expect_text(text);
            end
        end
    endtask

    task automatic check_char(input logic [7:0] data, input logic last);
        ascii_char_t want;
        if (expected_chars.size() == 0)
        begin
            report_mismatch($sformatf("unexpected character 0x%02h", data));
        end
        else
        begin
            want = expected_chars.pop_front();
            if (data !== {2'b00, want.character})
            begin
                report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                          data, want.character));
            end
            if (last !== want.last)
            begin
                report_mismatch($sformatf("tlast %b, expected %b on character 0x%02h",
                                          last, want.last, want.character));
            end
        end
    endtask

    // watch both sides at the clock edge, in one process so order is fixed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                take_value(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_char(m_axis_tdata, m_axis_tlast);
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [31:0] values[$];
        string       texts[$];
        longint      lo;
        longint      hi;
        longint      mag;
        int          ndig;
        int          total;

        // directed values, text typed in where it is plain to read
        values.push_back(32'd0);          texts.push_back("0");
        values.push_back(32'd1);          texts.push_back("1");
        values.push_back(-32'sd1);        texts.push_back("-1");
        values.push_back(32'd9);          texts.push_back("9");
        values.push_back(32'd10);         texts.push_back("10");
        values.push_back(-32'sd10);       texts.push_back("-10");
        values.push_back(32'd99);         texts.push_back("99");
        values.push_back(32'd100);        texts.push_back("100");
        values.push_back(32'd12345);      texts.push_back("12345");
        values.push_back(-32'sd999999999); texts.push_back("-999999999");
        values.push_back(32'd1000000000); texts.push_back("1000000000");
        values.push_back(32'h7fffffff);   texts.push_back("2147483647");
        values.push_back(32'h80000001);   texts.push_back("-2147483647");
        values.push_back(32'h80000000);   texts.push_back("-2147483648");
        values.push_back(32'h55555555);   texts.push_back("");
        values.push_back(32'haaaaaaaa);   texts.push_back("");
        values.push_back(32'h0000ffff);   texts.push_back("");
        values.push_back(32'hffff0000);   texts.push_back("");

        // random values: mostly a chosen number of digits, some raw words
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if ($urandom_range(3) == 0)
            begin
                values.push_back($urandom);
            end
            else
            begin
                ndig = $urandom_range(1, 10);
                lo = (ndig == 1) ? 0 : 64'd10 ** (ndig - 1);
                hi = (64'd10 ** ndig) - 1;
                if (hi > 64'h7fffffff)
                begin
                    hi = 64'h7fffffff;
                end
                mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
                if ($urandom_range(1) == 1)
                begin
                    mag = -mag;
                end
                values.push_back(32'(mag));
            end
            texts.push_back("");
        end
        total = values.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < total; k++)
        begin
            // three idling phases: sender light, then receiver light, then none
            if (k < total / 3)
            begin
                tx_idle_pct = 35;
                rx_idle_pct = 86;
            end
            else if (k < 2 * total / 3)
            begin
                tx_idle_pct = 86;
                rx_idle_pct = 35;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            while ($urandom_range(99) < tx_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata <= $urandom;
                @(posedge clk);
            end
            offered_text.push_back(texts[k]);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= values[k];
            @(posedge clk);
            while (!s_axis_tready)
            begin
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then give stray characters a chance to show
        while (offered_text.size() != 0 || expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
